### hdl/nco_pkg.sv
// package for the cosine oscillator: sizes, register codes, stage types, cosine table builder
package nco_pkg;

  // core sizes
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  // fixed port and field widths
  localparam int STEP_BITS      = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;
  localparam int AMP_BITS       = 16;
  localparam int COS_BITS       = 16;

  // derived sizes
  localparam int TBL_N         = 1 << TABLE_ADDR_BITS;
  localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
  localparam int SUM_BITS      = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
  localparam int PROD_BITS     = AMP_BITS + COS_BITS;
  localparam int P_BITS        = PROD_BITS + 2;
  localparam int OUT_SHIFT     = 31 - SAMPLE_BITS;

  // series terms stay below 2^33, so a 36-bit quotient covers them
  localparam int DIV_BITS      = 36;

  localparam logic [AMP_BITS-1:0] AMP_RESET = AMP_BITS'(16384);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE = CFG_INDEX_BITS'(1);

  // fixed-point constants for the table build
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1 <<< 30;
  localparam longint ROUND_Q15   = 64'sd1 <<< 14;

  // accumulator load from a start phase write
  typedef struct packed {
    logic                  load;
    logic [PHASE_BITS-1:0] value;
  } phase_load_t;

  // phase stage to table stage
  typedef struct packed {
    logic                  valid;
    logic [PHASE_BITS-1:0] phase;
  } phase_stage_t;

  // table stage to scaling stage
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [COS_BITS-1:0] mag;
  } cos_stage_t;

  typedef logic [COS_BITS-1:0] cos_table_t [0:TBL_N];

  // divisors of the cosine series, innermost term first
  function automatic longint horner_div(input int i);
    longint d;
    case (i)
      0:       d = 240;
      1:       d = 182;
      2:       d = 132;
      3:       d = 90;
      4:       d = 56;
      5:       d = 30;
      6:       d = 12;
      default: d = 2;
    endcase
    return d;
  endfunction

  // quotient truncated toward zero by shift and subtract
  function automatic longint div_trunc(input longint num, input longint den);
    longint mag;
    longint rem;
    longint quo;
    mag = (num < 0) ? -num : num;
    rem = 0;
    quo = 0;
    for (int b = DIV_BITS - 1; b >= 0; b--) begin
      rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return (num < 0) ? -quo : quo;
  endfunction

  // quarter-wave cosine in Q1.15, entries 0 to TBL_N inclusive
  function automatic cos_table_t build_cos_table();
    cos_table_t tbl;
    longint     x;
    longint     x2;
    longint     r;
    longint     scaled;
    for (int k = 0; k <= TBL_N; k++) begin
      x  = (HALF_PI_Q30 * longint'(k)) >>> TABLE_ADDR_BITS;
      x2 = (x * x) >>> 30;
      r  = Q30_ONE;
      for (int i = 0; i < 8; i++) begin
        scaled = (x2 * r) >>> 30;
        r      = Q30_ONE - div_trunc(scaled, horner_div(i));
      end
      if (r < 0) begin
        r = 0;
      end
      tbl[k] = COS_BITS'((r + ROUND_Q15) >>> 15);
    end
    return tbl;
  endfunction

endpackage

### hdl/nco_phase_acc.sv
// phase accumulator stage: adds each phase step and holds the new phase
module nco_phase_acc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_valid,
  input  logic [nco_pkg::STEP_BITS-1:0] step,
  input  nco_pkg::phase_load_t        phase_load,
  input  logic                        take_next,
  output logic                        take,
  output nco_pkg::phase_stage_t       stage
);
  import nco_pkg::*;

  logic                  valid;
  logic [PHASE_BITS-1:0] acc;
  logic [SUM_BITS-1:0]   sum;

  // stage can load when empty or when the next stage takes its item
  assign take = !valid || take_next;

  // wrapping add of the step
  assign sum = SUM_BITS'(acc) + SUM_BITS'(step);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= step_valid;
    end
  end

  // accumulator, loaded by a start phase write
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (phase_load.load) begin
      acc <= phase_load.value;
    end else if (step_valid && take) begin
      acc <= sum[PHASE_BITS-1:0];
    end
  end

  assign stage.valid = valid;
  assign stage.phase = acc;

endmodule

### hdl/nco_cos_rom.sv
// table stage: quarter-wave cosine rom with registered read and sign
module nco_cos_rom (
  input  logic                  clk,
  input  logic                  rst,
  input  nco_pkg::phase_stage_t in_stage,
  input  logic                  take_next,
  output logic                  take,
  output nco_pkg::cos_stage_t   out_stage
);
  import nco_pkg::*;

  localparam cos_table_t COS_TABLE = build_cos_table();

  logic [1:0]                 quadrant;
  logic [TABLE_ADDR_BITS-1:0] offset;
  logic [ROM_ADDR_BITS-1:0]   addr;
  logic                       valid;
  logic                       neg;
  logic [COS_BITS-1:0]        mag;

  assign take = !valid || take_next;

  // quadrant folding: odd quadrants read the table backwards
  assign quadrant = in_stage.phase[PHASE_BITS-1 -: 2];
  assign offset   = in_stage.phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign addr     = quadrant[0] ? (ROM_ADDR_BITS'(TBL_N) - ROM_ADDR_BITS'(offset))
                                : ROM_ADDR_BITS'(offset);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_stage.valid;
    end
  end

  // rom read, negative in the second and third quadrants
  always_ff @(posedge clk) begin
    if (take && in_stage.valid) begin
      mag <= COS_TABLE[addr];
      neg <= quadrant[0] ^ quadrant[1];
    end
  end

  assign out_stage.valid = valid;
  assign out_stage.neg   = neg;
  assign out_stage.mag   = mag;

endmodule

### hdl/nco_scale.sv
// scaling stages: amplitude multiply, then sign, round and saturate into the output register
module nco_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  nco_pkg::cos_stage_t                 in_stage,
  input  logic [nco_pkg::AMP_BITS-1:0]        amplitude,
  input  logic                                sample_stall,
  output logic                                take,
  output logic                                sample_valid,
  output logic signed [nco_pkg::SAMPLE_BITS-1:0] sample
);
  import nco_pkg::*;

  localparam logic signed [P_BITS-1:0] HALF = P_BITS'(1) << (OUT_SHIFT - 1);
  localparam logic signed [P_BITS-1:0] SMAX =
    (P_BITS'(1) << (SAMPLE_BITS - 1)) - P_BITS'(1);
  localparam logic signed [P_BITS-1:0] SMIN = ~SMAX;

  logic                          prod_valid;
  logic                          prod_neg;
  logic [PROD_BITS-1:0]          prod;
  logic                          take_out;
  logic signed [P_BITS-1:0]      p_signed;
  logic signed [P_BITS-1:0]      rounded;
  logic signed [P_BITS-1:0]      s_full;
  logic signed [SAMPLE_BITS-1:0] sample_next;

  assign take_out = !sample_valid || !sample_stall;
  assign take     = !prod_valid || take_out;

  // product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (take) begin
      prod_valid <= in_stage.valid;
    end
  end

  // unsigned amplitude times table magnitude
  always_ff @(posedge clk) begin
    if (take && in_stage.valid) begin
      prod     <= PROD_BITS'(amplitude) * PROD_BITS'(in_stage.mag);
      prod_neg <= in_stage.neg;
    end
  end

  // apply sign, round half up, floor shift, clamp
  always_comb begin
    p_signed = prod_neg ? -$signed(P_BITS'(prod)) : $signed(P_BITS'(prod));
    rounded  = p_signed + HALF;
    s_full   = rounded >>> OUT_SHIFT;
    if (s_full > SMAX) begin
      sample_next = SMAX[SAMPLE_BITS-1:0];
    end else if (s_full < SMIN) begin
      sample_next = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sample_next = s_full[SAMPLE_BITS-1:0];
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (take_out) begin
      sample_valid <= prod_valid;
    end
  end

  // output sample register
  always_ff @(posedge clk) begin
    if (take_out && prod_valid) begin
      sample <= sample_next;
    end
  end

endmodule

### hdl/cosine_nco.sv
// Cosine oscillator, top level.
// Input channel phase_step_valid / phase_step_stall / phase_step carries one
// 32-bit tuning word per transfer. Each transfer adds the word to the phase
// accumulator and yields one sample on sample_valid / sample_stall / sample:
// amplitude times the cosine of the new phase, rounded and saturated.
// Each phase step passes through the accumulator, table read, multiply
// and output registers in that order before its sample is offered.
// Throughput: one sample per unstalled cycle, set by the single accumulator
// add that feeds back; the other stages are plain pipeline registers. When
// the receiver stalls, each stage still fills its empty slot, so up to four
// items are held; phase_step_stall rises only once all stages are full.
// Configuration: cfg_write_en with cfg_index 0 writes amplitude (Q1.15,
// low 16 bits of cfg_data), index 1 writes start_phase and loads the
// accumulator. Write only while the pipeline is empty.
// Reset (rst, synchronous): pipeline emptied, accumulator zero, amplitude
// 16384; phase_step_stall is high during reset.
module cosine_nco (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   phase_step_valid,
  output logic                                   phase_step_stall,
  input  logic [nco_pkg::STEP_BITS-1:0]          phase_step,
  output logic                                   sample_valid,
  input  logic                                   sample_stall,
  output logic signed [nco_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   cfg_write_en,
  input  logic [nco_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [nco_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import nco_pkg::*;

  logic [AMP_BITS-1:0] amplitude;
  phase_load_t         phase_load;
  phase_stage_t        phase_stage;
  cos_stage_t          cos_stage;
  logic                take_phase;
  logic                take_rom;
  logic                take_scale;
  logic [SUM_BITS-1:0] start_ext;

  // amplitude register
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_AMPLITUDE: amplitude <= cfg_data[AMP_BITS-1:0];
        default:       amplitude <= amplitude;
      endcase
    end
  end

  // start phase write goes straight to the accumulator
  assign start_ext        = SUM_BITS'(cfg_data);
  assign phase_load.load  = cfg_write_en && (cfg_index == REG_START_PHASE);
  assign phase_load.value = start_ext[PHASE_BITS-1:0];

  assign phase_step_stall = rst || !take_phase;

  nco_phase_acc u_phase_acc (
    .clk        (clk),
    .rst        (rst),
    .step_valid (phase_step_valid && !rst),
    .step       (phase_step),
    .phase_load (phase_load),
    .take_next  (take_rom),
    .take       (take_phase),
    .stage      (phase_stage)
  );

  nco_cos_rom u_cos_rom (
    .clk       (clk),
    .rst       (rst),
    .in_stage  (phase_stage),
    .take_next (take_scale),
    .take      (take_rom),
    .out_stage (cos_stage)
  );

  nco_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_stage     (cos_stage),
    .amplitude    (amplitude),
    .sample_stall (sample_stall),
    .take         (take_scale),
    .sample_valid (sample_valid),
    .sample       (sample)
  );

endmodule

### hdl/nco_checker.sv
// port-level checks for the cosine oscillator, bound to the top level
module nco_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   phase_step_valid,
  input logic                                   phase_step_stall,
  input logic [nco_pkg::STEP_BITS-1:0]          phase_step,
  input logic                                   sample_valid,
  input logic                                   sample_stall,
  input logic signed [nco_pkg::SAMPLE_BITS-1:0] sample,
  input logic                                   cfg_write_en,
  input logic [nco_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input logic [nco_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  // a stalled sample stays valid and unchanged
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample dropped or changed");

  // input backs up only when the output is full and stalled
  assert property (@(posedge clk) disable iff (rst)
    phase_step_stall |-> sample_valid && sample_stall)
    else $error("input stalled with room in the pipeline");

  // a fresh sample follows an earlier input transfer
  assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(phase_step_valid && !phase_step_stall, 4))
    else $error("sample appeared without a matching input transfer");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !sample_valid)
    else $error("sample valid right after reset");

endmodule

bind cosine_nco nco_checker u_nco_checker (.*);
